@@ rtl/core/pfc_pkg.sv @@
// Pixel format converter package: format codes, beat payload types and
// stage-to-stage structs. No dependencies.
package pfc_pkg;

	typedef enum logic [2:0] {
		FMT_RGB24    = 3'd0,
		FMT_ARGB8888 = 3'd1,
		FMT_RGB565   = 3'd2,
		FMT_RGBA1555 = 3'd3,
		FMT_RGBA4444 = 3'd4,
		FMT_GRAY8    = 3'd5
	} fmt_t;

	localparam logic [0:0] REG_SOURCE_FORMAT = 1'b0;
	localparam logic [0:0] REG_TARGET_FORMAT = 1'b1;
	localparam int unsigned CFG_INDEX_W = 8;
	localparam int unsigned CFG_DATA_W  = 8;

	localparam logic [15:0] LUMA_WR = 16'd19595;
	localparam logic [15:0] LUMA_WG = 16'd38470;
	localparam logic [15:0] LUMA_WB = 16'd7471;

	typedef struct packed {
		logic [31:0] pixel_in;
		logic        last_in;
	} pixel_in_t;

	typedef struct packed {
		logic [31:0] pixel_out;
		logic        last_out;
		logic        pair_unsupported;
	} pixel_out_t;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		fmt_t       target;
		logic       bad;
		logic       last;
	} chan_t;

	typedef struct packed {
		chan_t       chan;
		logic [23:0] pr;
		logic [23:0] pg;
		logic [23:0] pb;
	} prod_t;

endpackage

@@ rtl/core/pfc_unpack.sv @@
// Stage 1: unpacks the source pixel into 8-bit A/R/G/B channels and checks the
// format pair. Depends on pfc_pkg.
module pfc_unpack
	import pfc_pkg::*;
(
	input  logic      clk,
	input  logic      en,
	input  pixel_in_t in_data,
	input  fmt_t      source_format,
	input  fmt_t      target_format,
	output chan_t     chan_s1
);

	chan_t       c;
	logic [31:0] p;
	logic [15:0] h;
	logic        src_ok;
	logic        tgt_ok;

	assign p = in_data.pixel_in;
	assign h = p[15:0];

	always_comb begin
		c = '0;
		c.a = 8'hFF;
		case (source_format)
			FMT_RGB24: begin
				c.r = p[7:0];
				c.g = p[15:8];
				c.b = p[23:16];
			end
			FMT_ARGB8888: begin
				c.a = p[7:0];
				c.r = p[15:8];
				c.g = p[23:16];
				c.b = p[31:24];
			end
			FMT_RGB565: begin
				c.r = {h[15:11], 3'b000};
				c.g = {h[10:5], 2'b00};
				c.b = {h[4:0], 3'b000};
			end
			FMT_RGBA1555: begin
				c.a = {8{h[15]}};
				c.r = {h[14:10], 3'b000};
				c.g = {h[9:5], 3'b000};
				c.b = {h[4:0], 3'b000};
			end
			FMT_RGBA4444: begin
				c.r = {h[15:12], 4'b0000};
				c.g = {h[11:8], 4'b0000};
				c.b = {h[7:4], 4'b0000};
				c.a = {h[3:0], 4'b0000};
			end
			FMT_GRAY8: begin
				c.r = p[7:0];
				c.g = p[7:0];
				c.b = p[7:0];
			end
			default: begin
				c.a = 8'h00;
			end
		endcase
		src_ok = (source_format == FMT_RGB24) || (source_format == FMT_RGB565)
			|| (source_format == FMT_RGBA1555) || (source_format == FMT_RGBA4444)
			|| (source_format == FMT_GRAY8);
		tgt_ok = (target_format == FMT_RGB24) || (target_format == FMT_RGB565)
			|| (target_format == FMT_RGBA1555) || (target_format == FMT_RGBA4444)
			|| (target_format == FMT_GRAY8);
		c.bad = !(((target_format == FMT_ARGB8888) && src_ok)
			|| ((source_format == FMT_ARGB8888) && tgt_ok)
			|| ((target_format == FMT_GRAY8)
				&& ((source_format == FMT_RGB24) || (source_format == FMT_RGB565))));
		c.target = target_format;
		c.last = in_data.last_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			chan_s1 <= c;
		end
	end

endmodule

@@ rtl/core/pfc_luma.sv @@
// Stage 2: weighted luma products of the R, G and B channels.
// Depends on pfc_pkg.
module pfc_luma
	import pfc_pkg::*;
(
	input  logic  clk,
	input  logic  en,
	input  chan_t chan_s1,
	output prod_t prod_s2
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2.chan <= chan_s1;
			prod_s2.pr   <= 24'(LUMA_WR) * 24'(chan_s1.r);
			prod_s2.pg   <= 24'(LUMA_WG) * 24'(chan_s1.g);
			prod_s2.pb   <= 24'(LUMA_WB) * 24'(chan_s1.b);
		end
	end

endmodule

@@ rtl/core/pfc_pack.sv @@
// Stage 3: sums luma products and packs channels into the target format.
// Depends on pfc_pkg.
module pfc_pack
	import pfc_pkg::*;
(
	input  logic       clk,
	input  logic       en,
	input  prod_t      prod_s2,
	output pixel_out_t data_s3
);

	chan_t       c;
	logic [23:0] sum;
	logic [7:0]  y;
	logic [31:0] res;

	assign c   = prod_s2.chan;
	assign sum = prod_s2.pr + prod_s2.pg + prod_s2.pb;
	assign y   = sum[23:16];

	always_comb begin
		case (c.target)
			FMT_RGB24:    res = {8'h00, c.b, c.g, c.r};
			FMT_ARGB8888: res = {c.b, c.g, c.r, c.a};
			FMT_RGB565:   res = {16'h0000, c.r[7:3], c.g[7:2], c.b[7:3]};
			FMT_RGBA1555: res = {16'h0000, c.a[7], c.r[7:3], c.g[7:3], c.b[7:3]};
			FMT_RGBA4444: res = {16'h0000, c.r[7:4], c.g[7:4], c.b[7:4], c.a[7:4]};
			FMT_GRAY8:    res = {24'h000000, y};
			default:      res = '0;
		endcase
		if (c.bad) begin
			res = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s3.pixel_out        <= res;
			data_s3.last_out         <= c.last;
			data_s3.pair_unsupported <= c.bad;
		end
	end

endmodule

@@ rtl/core/pixel_format_converter_unit.sv @@
// Pixel format converter top level: config registers, stage valids and stall.
// Beats pass unpack, luma and pack stages; one beat per cycle unless stalled.
// Each stage advances when it is empty or the stage after it advances, so a
// held output still lets earlier stages fill. Depends on pfc_pkg and stages.
// Reset clears all stage valids; source_format to RGB24, target to ARGB8888.
module pixel_format_converter_unit
	import pfc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  pixel_in_t              in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output pixel_out_t             out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	fmt_t       source_format_q;
	fmt_t       target_format_q;
	logic       valid_s1, valid_s2, valid_s3;
	logic       en_s1, en_s2, en_s3;
	chan_t      chan_s1;
	prod_t      prod_s2;
	pixel_out_t data_s3;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_format_q <= FMT_RGB24;
			target_format_q <= FMT_ARGB8888;
		end else if (cfg_valid && cfg_ready
			&& (cfg_index[CFG_INDEX_W-1:1] == '0)) begin
			if (cfg_index[0] == REG_SOURCE_FORMAT) begin
				source_format_q <= fmt_t'(cfg_data[2:0]);
			end else begin
				target_format_q <= fmt_t'(cfg_data[2:0]);
			end
		end
	end

	assign en_s3    = !valid_s3 || !out_stall;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
		end
	end

	pfc_unpack u_unpack (
		.clk           (clk),
		.en            (en_s1 && in_valid),
		.in_data       (in_data),
		.source_format (source_format_q),
		.target_format (target_format_q),
		.chan_s1       (chan_s1)
	);

	pfc_luma u_luma (
		.clk     (clk),
		.en      (en_s2 && valid_s1),
		.chan_s1 (chan_s1),
		.prod_s2 (prod_s2)
	);

	pfc_pack u_pack (
		.clk     (clk),
		.en      (en_s3 && valid_s2),
		.prod_s2 (prod_s2),
		.data_s3 (data_s3)
	);

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.pair_unsupported |-> out_data.pixel_out == '0)
		else $error("unsupported pair beat carries nonzero pixel");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && valid_s3 && out_stall)
		else $error("input stalled while pipeline has room");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted beat lost at stage 1");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && out_stall |=> valid_s3 && $stable(data_s3))
		else $error("held result changed");

endmodule

@@ tb/pixel_format_converter_unit_test.sv @@
// Testbench for pixel_format_converter_unit: random format pairs, pixels and stalls,
// with a scoreboard class that predicts every output beat from the accepted input beats.
// Depends on pfc_pkg and the converter RTL.
module pixel_format_converter_unit_test;
	import pfc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned REG_COUNT    = 2;
	localparam int unsigned LATENCY      = 3;
	localparam int unsigned RANDOM_ITEMS = 850;
	localparam int unsigned QUIET_AFTER  = 700;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned CYCLE_LIMIT  = 300000;

	class pixel_scoreboard;
		logic [2:0] src_fmt;
		logic [2:0] tgt_fmt;
		pixel_out_t pending_q[$];
		int errors;

		function new();
			src_fmt = FMT_RGB24;
			tgt_fmt = FMT_ARGB8888;
			errors = 0;
		endfunction

		function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == CFG_INDEX_W'(REG_SOURCE_FORMAT))
				src_fmt = val[2:0];
			else if (idx == CFG_INDEX_W'(REG_TARGET_FORMAT))
				tgt_fmt = val[2:0];
		endfunction

		function logic [7:0] luma(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			int unsigned acc;
			acc = int'(LUMA_WR) * r + int'(LUMA_WG) * g + int'(LUMA_WB) * b;
			return acc[23:16];
		endfunction

		function logic [31:0] pack_argb(logic [7:0] a, logic [7:0] r, logic [7:0] g,
				logic [7:0] b);
			return {b, g, r, a};
		endfunction

		function pixel_out_t convert(pixel_in_t px);
			pixel_out_t res;
			logic [15:0] h;
			logic [7:0] b0, b1, b2, b3;
			logic bad;
			logic [31:0] word;
			h = px.pixel_in[15:0];
			{b3, b2, b1, b0} = px.pixel_in;
			word = '0;
			bad = 1'b0;
			if (tgt_fmt == FMT_ARGB8888) begin
				case (src_fmt)
					FMT_RGB24: word = pack_argb(8'hFF, b0, b1, b2);
					FMT_RGB565: word = pack_argb(8'hFF, {h[15:11], 3'b0}, {h[10:5], 2'b0},
						{h[4:0], 3'b0});
					FMT_RGBA1555: word = pack_argb({8{h[15]}}, {h[14:10], 3'b0},
						{h[9:5], 3'b0}, {h[4:0], 3'b0});
					FMT_RGBA4444: word = pack_argb({h[3:0], 4'b0}, {h[15:12], 4'b0},
						{h[11:8], 4'b0}, {h[7:4], 4'b0});
					FMT_GRAY8: word = pack_argb(8'hFF, b0, b0, b0);
					default: bad = 1'b1;
				endcase
			end else if (src_fmt == FMT_ARGB8888) begin
				case (tgt_fmt)
					FMT_RGB24: word = {8'h00, b3, b2, b1};
					FMT_RGB565: word = {16'h0, b1[7:3], b2[7:2], b3[7:3]};
					FMT_RGBA1555: word = {16'h0, b0[7], b1[7:3], b2[7:3], b3[7:3]};
					FMT_RGBA4444: word = {16'h0, b1[7:4], b2[7:4], b3[7:4], b0[7:4]};
					FMT_GRAY8: word = {24'h0, luma(b1, b2, b3)};
					default: bad = 1'b1;
				endcase
			end else if (tgt_fmt == FMT_GRAY8 && src_fmt == FMT_RGB24) begin
				word = {24'h0, luma(b0, b1, b2)};
			end else if (tgt_fmt == FMT_GRAY8 && src_fmt == FMT_RGB565) begin
				word = {24'h0, luma({h[15:11], 3'b0}, {h[10:5], 2'b0}, {h[4:0], 3'b0})};
			end else begin
				bad = 1'b1;
			end
			res.pixel_out = bad ? 32'h0 : word;
			res.last_out = px.last_in;
			res.pair_unsupported = bad;
			return res;
		endfunction

		function void note_pixel(pixel_in_t px);
			pending_q.push_back(convert(px));
		endfunction

		function void check_pixel(pixel_out_t got);
			pixel_out_t want;
			if (pending_q.size() == 0) begin
				$error("output beat %h with no pending expectation", got);
				errors++;
				return;
			end
			want = pending_q.pop_front();
			if (got.pixel_out !== want.pixel_out) begin
				$error("pixel_out expected %h actual %h", want.pixel_out, got.pixel_out);
				errors++;
			end
			if (got.last_out !== want.last_out) begin
				$error("last_out expected %b actual %b", want.last_out, got.last_out);
				errors++;
			end
			if (got.pair_unsupported !== want.pair_unsupported) begin
				$error("pair_unsupported expected %b actual %b", want.pair_unsupported,
					got.pair_unsupported);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_q.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	pixel_in_t              in_data;
	logic                   out_valid;
	logic                   out_stall;
	pixel_out_t             out_data;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	pixel_scoreboard sb;
	int unsigned cycles;
	int unsigned hold_requests;
	bit quiet;

	pixel_format_converter_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cycles = 0;
		hold_requests = 0;
		quiet = 1'b0;
		sb = new();
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (cfg_valid && cfg_ready)
			sb.write_register(cfg_index, cfg_data);
		if (in_valid && !in_stall)
			sb.note_pixel(in_data);
		if (out_valid && !out_stall)
			sb.check_pixel(out_data);
	end

	initial begin : receiver
		int unsigned holds_done;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_done) begin
				holds_done++;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 9) == 0) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic pixel_in_t pix(logic [31:0] v, logic l);
		pixel_in_t p;
		p.pixel_in = v;
		p.last_in = l;
		return p;
	endfunction

	function automatic pixel_in_t random_pixel();
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0: v = 32'h0000_0000;
			1: v = 32'hFFFF_FFFF;
			default: v = $urandom;
		endcase
		return pix(v, $urandom_range(0, 3) == 0);
	endfunction

	task automatic send_pixel(input pixel_in_t px);
		in_data <= px;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_formats(input logic [2:0] src, input logic [2:0] tgt);
		logic [CFG_DATA_W-1:0] v;
		drain();
		if ($urandom_range(0, 3) == 0)
			write_register(CFG_INDEX_W'($urandom_range(REG_COUNT, 255)), CFG_DATA_W'($urandom));
		v = CFG_DATA_W'($urandom);
		v[2:0] = src;
		write_register(CFG_INDEX_W'(REG_SOURCE_FORMAT), v);
		v = CFG_DATA_W'($urandom);
		v[2:0] = tgt;
		write_register(CFG_INDEX_W'(REG_TARGET_FORMAT), v);
		cfg_valid <= 1'b0;
	endtask

	task automatic pick_pair(output logic [2:0] src, output logic [2:0] tgt);
		logic [2:0] narrow;
		if ($urandom_range(0, 3) == 0) begin
			src = 3'($urandom_range(0, 7));
			tgt = 3'($urandom_range(0, 7));
			return;
		end
		case ($urandom_range(0, 4))
			0: narrow = FMT_RGB24;
			1: narrow = FMT_RGB565;
			2: narrow = FMT_RGBA1555;
			3: narrow = FMT_RGBA4444;
			default: narrow = FMT_GRAY8;
		endcase
		case ($urandom_range(0, 4))
			0, 1: begin
				src = FMT_ARGB8888;
				tgt = narrow;
			end
			2, 3: begin
				src = narrow;
				tgt = FMT_ARGB8888;
			end
			default: begin
				src = ($urandom_range(0, 1) == 0) ? FMT_RGB24 : FMT_RGB565;
				tgt = FMT_GRAY8;
			end
		endcase
	endtask

	initial begin : sender
		int unsigned sent;
		int unsigned phase;
		int unsigned count;
		logic [2:0] src, tgt;
		sent = 0;
		phase = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_pixel(pix(32'h0000_0000, 1'b0));
		send_pixel(pix(32'hFFFF_FFFF, 1'b1));
		send_pixel(pix(32'h0012_3456, 1'b0));

		set_formats(FMT_ARGB8888, FMT_RGBA1555);
		send_pixel(pix(32'hFFFF_FF7F, 1'b0));
		send_pixel(pix(32'h0000_0080, 1'b1));
		send_pixel(pix(32'h0000_0000, 1'b0));
		send_pixel(pix(32'hFFFF_FFFF, 1'b1));

		set_formats(FMT_ARGB8888, FMT_GRAY8);
		send_pixel(pix(32'hFFFF_FFFF, 1'b0));
		send_pixel(pix(32'h0000_0000, 1'b1));

		set_formats(FMT_RGB565, FMT_GRAY8);
		send_pixel(pix(32'h0000_FFFF, 1'b0));
		send_pixel(pix(32'hFFFF_0000, 1'b1));

		set_formats(FMT_RGBA1555, FMT_ARGB8888);
		send_pixel(pix(32'h0000_8000, 1'b0));
		send_pixel(pix(32'hFFFF_7FFF, 1'b1));

		set_formats(FMT_ARGB8888, FMT_ARGB8888);
		send_pixel(pix(32'hA5A5_5A5A, 1'b1));

		set_formats(3'd7, FMT_ARGB8888);
		send_pixel(pix(32'hFFFF_FFFF, 1'b0));

		set_formats(FMT_ARGB8888, 3'd6);
		send_pixel(pix(32'h1234_5678, 1'b1));

		drain();
		write_register(CFG_INDEX_W'(255), 8'hFF);
		write_register(CFG_INDEX_W'(REG_COUNT), 8'h00);
		write_register(CFG_INDEX_W'(REG_SOURCE_FORMAT), CFG_DATA_W'(FMT_GRAY8));
		write_register(CFG_INDEX_W'(REG_TARGET_FORMAT), CFG_DATA_W'(FMT_ARGB8888));
		cfg_valid <= 1'b0;
		send_pixel(pix(32'hFFFF_FFFF, 1'b0));

		while (sent < RANDOM_ITEMS) begin
			pick_pair(src, tgt);
			set_formats(src, tgt);
			if (sent >= QUIET_AFTER)
				quiet <= 1'b1;
			if (phase == 2 || phase == 20)
				hold_requests <= hold_requests + 1;
			count = $urandom_range(8, 30);
			repeat (count) begin
				if (!quiet && phase != 2 && phase != 20 && $urandom_range(0, 4) == 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 17)) @(posedge clk);
				end
				send_pixel(random_pixel());
				sent++;
			end
			phase++;
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
